/* design/cha_pkg.sv */
// ----------------------------------------------------------------------------
// cha_pkg
// shared widths, character codes, line positions and the arctangent table
// for the compass heading to ascii unit
// ----------------------------------------------------------------------------
package cha_pkg;

	localparam int CORDIC_STAGES = 18;
	localparam int ATAN_LEN      = 24;
	localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

	localparam int MAG_W = 16;                 // input sample width
	localparam int ABS_W = MAG_W + 1;          // magnitude of a 16-bit sample
	localparam int XW    = ABS_W + 16 + 2;     // cordic x/y, headroom for gain
	localparam int ZW    = 34;                 // cordic angle, 2^32 counts a turn
	localparam int HW    = 32;                 // saturated heading
	localparam int TW    = 12;                 // tenths of a degree, 0..3600
	localparam int DW    = 4;                  // one decimal digit
	localparam int CW    = 7;                  // ascii character
	localparam int PW    = 3;                  // position within the line

	localparam logic [TW-1:0] TENTHS_PER_TURN = 12'd3600;
	localparam logic [TW-1:0] TENTHS_0        = 12'd0;
	localparam logic [TW-1:0] TENTHS_90       = 12'd900;
	localparam logic [TW-1:0] TENTHS_180      = 12'd1800;
	localparam logic [TW-1:0] TENTHS_270      = 12'd2700;

	localparam logic [CW-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CW-1:0] CHAR_DOT  = 7'h2E;
	localparam logic [CW-1:0] CHAR_CR   = 7'h0D;
	localparam logic [CW-1:0] CHAR_LF   = 7'h0A;

	localparam logic [PW-1:0] POS_THOU  = 3'd0;
	localparam logic [PW-1:0] POS_HUND  = 3'd1;
	localparam logic [PW-1:0] POS_TENS  = 3'd2;
	localparam logic [PW-1:0] POS_DOT   = 3'd3;
	localparam logic [PW-1:0] POS_TENTH = 3'd4;
	localparam logic [PW-1:0] POS_CR    = 3'd5;
	localparam logic [PW-1:0] POS_LF    = 3'd6;

	// side information that rides along the cordic pipeline
	typedef struct packed {
		logic          special;   // heading settled on an axis or at origin
		logic [TW-1:0] sp_tenths;
		logic          neg_x;
		logic          neg_y;
	} cha_side_t;

	// the four digits of one output line
	typedef struct packed {
		logic [DW-1:0] th;
		logic [DW-1:0] hu;
		logic [DW-1:0] te;
		logic [DW-1:0] tn;
	} cha_line_t;

	// atan(2^-i) in counts of 2^-32 turn, rounded to nearest
	function automatic logic [31:0] atan_turn(input int unsigned i);
		logic [31:0] a;
		case (i)
			0:       a = 32'h20000000;
			1:       a = 32'h12E4051E;
			2:       a = 32'h09FB385B;
			3:       a = 32'h051111D4;
			4:       a = 32'h028B0D43;
			5:       a = 32'h0145D7E1;
			6:       a = 32'h00A2F61E;
			7:       a = 32'h00517C55;
			8:       a = 32'h0028BE53;
			9:       a = 32'h00145F2F;
			10:      a = 32'h000A2F98;
			11:      a = 32'h000517CC;
			12:      a = 32'h00028BE6;
			13:      a = 32'h000145F3;
			14:      a = 32'h0000A2FA;
			15:      a = 32'h0000517D;
			16:      a = 32'h000028BE;
			17:      a = 32'h0000145F;
			18:      a = 32'h00000A30;
			19:      a = 32'h00000518;
			20:      a = 32'h0000028C;
			21:      a = 32'h00000146;
			22:      a = 32'h000000A3;
			23:      a = 32'h00000051;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	// r / 100 for r below 1000, by reciprocal multiply
	function automatic logic [DW-1:0] div100(input logic [9:0] r);
		logic [22:0] p;
		p = {13'd0, r} * 23'd5243;
		return p[22:19];
	endfunction

	// r / 10 for r below 100, by reciprocal multiply
	function automatic logic [DW-1:0] div10(input logic [6:0] r);
		logic [14:0] p;
		p = {8'd0, r} * 15'd205;
		return p[14:11];
	endfunction

endpackage

/* design/compass_heading_to_ascii_unit.sv */
// ----------------------------------------------------------------------------
// compass_heading_to_ascii_unit
// magnetometer x/y sample to a heading text line "ddd.d" CR LF
// ----------------------------------------------------------------------------
// Each request on the input stream is one signed x/y field sample; the unit
// answers with seven characters on the output stream: thousands, hundreds and
// tens digit, '.', tenths digit, CR and LF, with tlast on the LF. The heading
// is atan2(y, x) in degrees plus 180, truncated to tenths (000.0 to 360.0);
// both axes zero reads 180.0, and samples on an axis give exact headings.
// The angle comes from an 18-stage vectoring cordic, one rotation per
// register stage, so an input enters every cycle that the pipe is not held.
// The first character is offered once the request has passed the prep register,
// then 18 cordic, 2 scale and 3 digit stages and the sender register.
// The line sender emits one character per cycle while the output stream
// takes them, and takes the next line as the LF of the last is taken, so
// the output stream sets the sustained input rate.
// The whole pipe holds together when the sender is full, nothing is dropped.
// ----------------------------------------------------------------------------
module compass_heading_to_ascii_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] mag_x, [31:16] mag_y
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [6:0] char_out, [7] zero
	output logic        m_axis_tlast    // last_char
);
	import cha_pkg::*;

	// pipeline advance: all stages move together unless the last one is
	// full and the line sender cannot take it
	logic                 en;
	logic                 tx_ready;

	logic                 v_p;
	logic signed [XW-1:0] x_p, y_p;
	cha_side_t            side_p;

	logic                 v_c;
	logic signed [ZW-1:0] z_c;
	cha_side_t            side_c;

	logic                 v_t;
	logic [TW-1:0]        tenths_t;

	logic                 v_d;
	cha_line_t            line_d;

	logic [CW-1:0]        char_out;

	assign en            = !v_d || tx_ready;
	assign s_axis_tready = en;

	// magnitudes and axis special cases
	cha_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (s_axis_tvalid),
		.mag_x   ($signed(s_axis_tdata[15:0])),
		.mag_y   ($signed(s_axis_tdata[31:16])),
		.v_s1    (v_p),
		.x_s1    (x_p),
		.y_s1    (y_p),
		.side_s1 (side_p)
	);

	// first-quadrant angle
	cha_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_p),
		.x_in     (x_p),
		.y_in     (y_p),
		.side_in  (side_p),
		.v_out    (v_c),
		.z_out    (z_c),
		.side_out (side_c)
	);

	// full-turn heading scaled to tenths of a degree
	cha_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_in      (v_c),
		.z_in      (z_c),
		.side_in   (side_c),
		.v_s2      (v_t),
		.tenths_s2 (tenths_t)
	);

	// decimal digits
	cha_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_in      (v_t),
		.tenths_in (tenths_t),
		.v_s3      (v_d),
		.line_s3   (line_d)
	);

	// character sender, doubles as the output register
	cha_line_tx u_line_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_in     (v_d),
		.line_in  (line_d),
		.ready    (tx_ready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_char   (char_out),
		.m_tlast  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, char_out};

endmodule

/* design/cha_prep.sv */
// ----------------------------------------------------------------------------
// cha_prep
// first stage: magnitudes into cordic format, quadrant and axis cases
// ----------------------------------------------------------------------------
module cha_prep (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           v_in,
	input  logic signed [cha_pkg::MAG_W-1:0] mag_x,
	input  logic signed [cha_pkg::MAG_W-1:0] mag_y,
	output logic                           v_s1,
	output logic signed [cha_pkg::XW-1:0]  x_s1,
	output logic signed [cha_pkg::XW-1:0]  y_s1,
	output cha_pkg::cha_side_t             side_s1
);
	import cha_pkg::*;

	logic [ABS_W-1:0] ax, ay;
	cha_side_t        side_d;

	always_comb begin
		ax = mag_x[MAG_W-1] ? ABS_W'(-{mag_x[MAG_W-1], mag_x}) : ABS_W'({1'b0, mag_x});
		ay = mag_y[MAG_W-1] ? ABS_W'(-{mag_y[MAG_W-1], mag_y}) : ABS_W'({1'b0, mag_y});
		side_d.neg_x     = mag_x[MAG_W-1];
		side_d.neg_y     = mag_y[MAG_W-1];
		side_d.special   = 1'b1;
		side_d.sp_tenths = TENTHS_180;
		if (mag_y == '0) begin
			side_d.sp_tenths = mag_x[MAG_W-1] ? TENTHS_PER_TURN : TENTHS_180;
		end else if (mag_x == '0) begin
			side_d.sp_tenths = mag_y[MAG_W-1] ? TENTHS_90 : TENTHS_270;
		end else begin
			side_d.special   = 1'b0;
			side_d.sp_tenths = TENTHS_0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= $signed({2'b00, ax, 16'd0});
			y_s1    <= $signed({2'b00, ay, 16'd0});
			side_s1 <= side_d;
		end
	end

endmodule

/* design/cha_cordic.sv */
// ----------------------------------------------------------------------------
// cha_cordic
// vectoring cordic, one rotation per pipeline stage
// ----------------------------------------------------------------------------
module cha_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_in,
	input  logic signed [cha_pkg::XW-1:0] x_in,
	input  logic signed [cha_pkg::XW-1:0] y_in,
	input  cha_pkg::cha_side_t            side_in,
	output logic                          v_out,
	output logic signed [cha_pkg::ZW-1:0] z_out,
	output cha_pkg::cha_side_t            side_out
);
	import cha_pkg::*;

	logic                 v_sn    [CORDIC_N];
	logic signed [XW-1:0] x_sn    [CORDIC_N];
	logic signed [XW-1:0] y_sn    [CORDIC_N];
	logic signed [ZW-1:0] z_sn    [CORDIC_N];
	cha_side_t            side_sn [CORDIC_N];

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
		logic                 vp;
		logic signed [XW-1:0] xp, yp, xs, ys, xn, yn;
		logic signed [ZW-1:0] zp, zn, at;
		cha_side_t            sp;

		if (i == 0) begin : g_first
			assign vp = v_in;
			assign xp = x_in;
			assign yp = y_in;
			assign zp = '0;
			assign sp = side_in;
		end else begin : g_next
			assign vp = v_sn[i-1];
			assign xp = x_sn[i-1];
			assign yp = y_sn[i-1];
			assign zp = z_sn[i-1];
			assign sp = side_sn[i-1];
		end

		always_comb begin
			at = $signed({2'b00, atan_turn(i)});
			xs = xp >>> i;
			ys = yp >>> i;
			if (!yp[XW-1]) begin
				xn = xp + ys;
				yn = yp - xs;
				zn = zp + at;
			end else begin
				xn = xp - ys;
				yn = yp + xs;
				zn = zp - at;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[i] <= 1'b0;
			end else if (en) begin
				v_sn[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_sn[i]    <= xn;
				y_sn[i]    <= yn;
				z_sn[i]    <= zn;
				side_sn[i] <= sp;
			end
		end
	end

	assign v_out    = v_sn[CORDIC_N-1];
	assign z_out    = z_sn[CORDIC_N-1];
	assign side_out = side_sn[CORDIC_N-1];

endmodule

/* design/cha_scale.sv */
// ----------------------------------------------------------------------------
// cha_scale
// quadrant fold to a full-turn heading, saturation, scaling to tenths; axis cases pass their fixed value
// ----------------------------------------------------------------------------
module cha_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_in,
	input  logic signed [cha_pkg::ZW-1:0] z_in,
	input  cha_pkg::cha_side_t            side_in,
	output logic                          v_s2,
	output logic [cha_pkg::TW-1:0]        tenths_s2
);
	import cha_pkg::*;

	localparam int SW = HW + 4;
	localparam logic signed [SW-1:0] TURN_HALF = 36'sh0_8000_0000;
	localparam logic signed [SW-1:0] TURN_FULL = 36'sh1_0000_0000;

	logic signed [SW-1:0] zx, hs;
	logic [HW-1:0]        h_d;
	logic [HW+TW-1:0]     prod;

	logic                 v_s1;
	logic [HW-1:0]        h_s1;
	cha_side_t            side_s1;

	always_comb begin
		zx = SW'(z_in);
		case ({side_in.neg_x, side_in.neg_y})
			2'b00:   hs = TURN_HALF + zx;
			2'b10:   hs = TURN_FULL - zx;
			2'b11:   hs = zx;
			default: hs = TURN_HALF - zx;
		endcase
		if (hs[SW-1]) begin
			h_d = '0;
		end else if (hs[SW-2:HW] != '0) begin
			h_d = '1;
		end else begin
			h_d = hs[HW-1:0];
		end
	end

	assign prod = {{TW{1'b0}}, h_s1} * {{HW{1'b0}}, TENTHS_PER_TURN};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1      <= h_d;
			side_s1   <= side_in;
			tenths_s2 <= side_s1.special ? side_s1.sp_tenths : prod[HW+TW-1:HW];
		end
	end

endmodule

/* design/cha_digits.sv */
// ----------------------------------------------------------------------------
// cha_digits
// tenths value split into four decimal digits over three stages
// ----------------------------------------------------------------------------
module cha_digits (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   v_in,
	input  logic [cha_pkg::TW-1:0] tenths_in,
	output logic                   v_s3,
	output cha_pkg::cha_line_t     line_s3
);
	import cha_pkg::*;

	logic [DW-1:0] th_d;
	logic [TW-1:0] r1_d;
	logic [DW-1:0] hu_d;
	logic [9:0]    r2_w;

	logic          v_s1, v_s2;
	logic [DW-1:0] th_s1, th_s2, hu_s2;
	logic [9:0]    r1_s1;
	logic [6:0]    r2_s2;
	logic [DW-1:0] te_d;
	logic [6:0]    tn_w;

	// thousands by compare, value never exceeds 3600
	always_comb begin
		if (tenths_in >= 12'd3000) begin
			th_d = 4'd3;
			r1_d = tenths_in - 12'd3000;
		end else if (tenths_in >= 12'd2000) begin
			th_d = 4'd2;
			r1_d = tenths_in - 12'd2000;
		end else if (tenths_in >= 12'd1000) begin
			th_d = 4'd1;
			r1_d = tenths_in - 12'd1000;
		end else begin
			th_d = 4'd0;
			r1_d = tenths_in;
		end
	end

	assign hu_d = div100(r1_s1);
	assign r2_w = r1_s1 - ({6'd0, hu_d} * 10'd100);
	assign te_d = div10(r2_s2);
	assign tn_w = r2_s2 - ({3'd0, te_d} * 7'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_s1      <= th_d;
			r1_s1      <= r1_d[9:0];
			th_s2      <= th_s1;
			hu_s2      <= hu_d;
			r2_s2      <= r2_w[6:0];
			line_s3.th <= th_s2;
			line_s3.hu <= hu_s2;
			line_s3.te <= te_d;
			line_s3.tn <= tn_w[DW-1:0];
		end
	end

endmodule

/* design/cha_line_tx.sv */
// ----------------------------------------------------------------------------
// cha_line_tx
// holds one line of digits and sends its seven characters in turn
// ----------------------------------------------------------------------------
module cha_line_tx (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   v_in,
	input  cha_pkg::cha_line_t     line_in,
	output logic                   ready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [cha_pkg::CW-1:0] m_char,
	output logic                   m_tlast
);
	import cha_pkg::*;

	logic          busy_q;
	logic [PW-1:0] cnt_q;
	cha_line_t     line_q;

	assign ready    = !busy_q || (m_tready && cnt_q == POS_LF);
	assign m_tvalid = busy_q;
	assign m_tlast  = (cnt_q == POS_LF);

	always_comb begin
		case (cnt_q)
			POS_THOU:  m_char = CHAR_ZERO + {3'b000, line_q.th};
			POS_HUND:  m_char = CHAR_ZERO + {3'b000, line_q.hu};
			POS_TENS:  m_char = CHAR_ZERO + {3'b000, line_q.te};
			POS_DOT:   m_char = CHAR_DOT;
			POS_TENTH: m_char = CHAR_ZERO + {3'b000, line_q.tn};
			POS_CR:    m_char = CHAR_CR;
			POS_LF:    m_char = CHAR_LF;
			default:   m_char = CHAR_LF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= POS_THOU;
		end else if (ready) begin
			busy_q <= v_in;
			cnt_q  <= POS_THOU;
		end else if (m_tready) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && v_in) begin
			line_q <= line_in;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= POS_LF)
		else $error("character position past end of line");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !m_tready) |=> (busy_q && $stable(cnt_q) && $stable(line_q)))
		else $error("line changed while stalled");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && m_tready && cnt_q != POS_LF) |=> (busy_q && cnt_q == $past(cnt_q) + 3'd1))
		else $error("character position did not advance");

	a_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q) |-> (cnt_q == POS_THOU))
		else $error("idle with a line part sent");

endmodule
